>>> hw/rtl/lcd4_pkg.sv
// package for the 4-bit character lcd interface
// holds op codes, register indexes, shared structs and the sequence rom
// no dependencies
`timescale 1ns / 1ps

package lcd4_pkg;

	// request op codes
	localparam logic [2:0] OP_CMD    = 3'd0;
	localparam logic [2:0] OP_DATA   = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_INIT   = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_WAIT = 8'd3;

	// register reset values
	localparam logic [7:0]  PULSE_RST = 8'd1;
	localparam logic [9:0]  SETTLE_RST = 10'd100;
	localparam logic [15:0] CLEAR_WAIT_RST = 16'd2000;
	localparam logic [15:0] POWER_WAIT_RST = 16'd50000;

	// fixed init waits
	localparam logic [15:0] WAIT_LONG_US = 16'd4500;
	localparam logic [15:0] WAIT_SHORT_US = 16'd150;

	// cursor command parts
	localparam logic [6:0] ROW1_OFFSET = 7'h40;

	// sequence rom layout
	localparam int unsigned PC_W = 5;
	localparam logic [PC_W-1:0] PC_INIT = 5'd0;
	localparam logic [PC_W-1:0] PC_CLEAR = 5'd14;
	localparam logic [PC_W-1:0] PC_BYTE = 5'd17;

	typedef enum logic {
		ELEM_NIB,
		ELEM_WAIT
	} elem_kind_t;

	typedef enum logic [1:0] {
		NSRC_CONST,
		NSRC_HI,
		NSRC_LO
	} nib_src_t;

	typedef enum logic [1:0] {
		WSEL_POWER,
		WSEL_LONG,
		WSEL_SHORT,
		WSEL_CLEAR
	} wait_sel_t;

	typedef struct packed {
		elem_kind_t kind;
		nib_src_t   nsrc;
		logic [3:0] nconst;
		wait_sel_t  wsel;
		logic       last;
	} elem_t;

	typedef struct packed {
		logic [7:0]  pulse;
		logic [9:0]  settle;
		logic [15:0] clear_wait;
		logic [15:0] power_wait;
	} cfg_t;

	typedef struct packed {
		logic        rs;
		logic        en;
		logic [3:0]  nibble;
		logic [15:0] hold;
		logic        last;
	} pin_state_t;

	function automatic elem_t mk_nib(nib_src_t src, logic [3:0] val, logic fin);
		elem_t e;
		e.kind = ELEM_NIB;
		e.nsrc = src;
		e.nconst = val;
		e.wsel = WSEL_CLEAR;
		e.last = fin;
		return e;
	endfunction

	function automatic elem_t mk_wait(wait_sel_t sel, logic fin);
		elem_t e;
		e.kind = ELEM_WAIT;
		e.nsrc = NSRC_CONST;
		e.nconst = 4'h0;
		e.wsel = sel;
		e.last = fin;
		return e;
	endfunction

	// init runs from PC_INIT straight into the clear sequence
	function automatic elem_t seq_rom(logic [PC_W-1:0] pc);
		elem_t e;
		case (pc)
			5'd0:    e = mk_wait(WSEL_POWER, 1'b0);
			5'd1:    e = mk_nib(NSRC_CONST, 4'h3, 1'b0);
			5'd2:    e = mk_wait(WSEL_LONG, 1'b0);
			5'd3:    e = mk_nib(NSRC_CONST, 4'h3, 1'b0);
			5'd4:    e = mk_wait(WSEL_LONG, 1'b0);
			5'd5:    e = mk_nib(NSRC_CONST, 4'h3, 1'b0);
			5'd6:    e = mk_wait(WSEL_SHORT, 1'b0);
			5'd7:    e = mk_nib(NSRC_CONST, 4'h2, 1'b0);
			5'd8:    e = mk_nib(NSRC_CONST, 4'h2, 1'b0);  // function set 0x28
			5'd9:    e = mk_nib(NSRC_CONST, 4'h8, 1'b0);
			5'd10:   e = mk_nib(NSRC_CONST, 4'h0, 1'b0);  // display on 0x0c
			5'd11:   e = mk_nib(NSRC_CONST, 4'hC, 1'b0);
			5'd12:   e = mk_nib(NSRC_CONST, 4'h0, 1'b0);  // entry mode 0x06
			5'd13:   e = mk_nib(NSRC_CONST, 4'h6, 1'b0);
			5'd14:   e = mk_nib(NSRC_CONST, 4'h0, 1'b0);  // clear 0x01
			5'd15:   e = mk_nib(NSRC_CONST, 4'h1, 1'b0);
			5'd16:   e = mk_wait(WSEL_CLEAR, 1'b1);
			5'd17:   e = mk_nib(NSRC_HI, 4'h0, 1'b0);
			5'd18:   e = mk_nib(NSRC_LO, 4'h0, 1'b1);
			default: e = mk_wait(WSEL_CLEAR, 1'b1);
		endcase
		return e;
	endfunction

endpackage

>>> hw/rtl/char_lcd_4bit_interface.sv
// top level of the 4-bit character lcd interface
// holds the configuration registers, ties lcd4_seq and lcd4_out together
// depends on lcd4_pkg, lcd4_seq, lcd4_out
`timescale 1ns / 1ps

//  channel   handshake               payload
//  request   in_valid / in_ready     op, byte_value, row, col
//  pin state out_valid / out_ready   rs_level, en_level, data_nibble, hold_us, last
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one pin state is produced per cycle while out_ready stays high; a request
// produces 6 (byte), 7 (clear) or 41 (init) pin states, a count set by the
// nibble pulse unit and the rom walker
// first pin state shows after the run state loads it into the output register
// in_ready is low from the request transaction until its last pin state is
// loaded into the output register; a full output register with out_ready low
// stalls the sequencer; reset restores register defaults and clears out_valid

module char_lcd_4bit_interface
	import lcd4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [7:0]           byte_value,
	input  logic [1:0]           row,
	input  logic [5:0]           col,
	// pin state channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 rs_level,
	output logic                 en_level,
	output logic [3:0]           data_nibble,
	output logic [15:0]          hold_us,
	output logic                 last,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t       cfg_q;
	logic       seq_idle;
	logic       seq_push;
	logic       out_space;
	pin_state_t seq_pin;
	pin_state_t out_pin;

	// configuration writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse <= PULSE_RST;
			cfg_q.settle <= SETTLE_RST;
			cfg_q.clear_wait <= CLEAR_WAIT_RST;
			cfg_q.power_wait <= POWER_WAIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PULSE:      cfg_q.pulse <= cfg_data[7:0];
				REG_SETTLE:     cfg_q.settle <= cfg_data[9:0];
				REG_CLEAR_WAIT: cfg_q.clear_wait <= cfg_data;
				REG_POWER_WAIT: cfg_q.power_wait <= cfg_data;
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// a request transaction is taken only while the sequencer rests;
	// unused op codes are taken and produce nothing
	assign in_ready = seq_idle;

	lcd4_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.start_op   (op),
		.start_byte (byte_value),
		.start_row  (row),
		.start_col  (col),
		.cfg        (cfg_q),
		.space      (out_space),
		.push       (seq_push),
		.pin        (seq_pin),
		.idle       (seq_idle)
	);

	lcd4_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (seq_push),
		.pin       (seq_pin),
		.space     (out_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.held      (out_pin)
	);

	assign rs_level = out_pin.rs;
	assign en_level = out_pin.en;
	assign data_nibble = out_pin.nibble;
	assign hold_us = out_pin.hold;
	assign last = out_pin.last;

`ifndef SYNTHESIS
	// a valid request keeps the sequencer busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_CMD || op == OP_DATA || op == OP_CURSOR ||
		op == OP_CLEAR || op == OP_INIT) |=> !in_ready)
		else $error("sequencer idle right after a request transaction");

	// while a non-final pin state waits, the request is still in progress
	a_no_ready_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request accepted before previous one finished");

	// a request never ends with the enable strobe high
	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && en_level |-> !last)
		else $error("final pin state has enable high");
`endif

endmodule

>>> hw/rtl/lcd4_seq.sv
// element sequencer: walks the sequence rom and reuses one nibble pulse unit
// emits one pin state per push; depends on lcd4_pkg
`timescale 1ns / 1ps

module lcd4_seq
	import lcd4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] start_op,
	input  logic [7:0] start_byte,
	input  logic [1:0] start_row,
	input  logic [5:0] start_col,
	input  cfg_t       cfg,
	input  logic       space,
	output logic       push,
	output pin_state_t pin,
	output logic       idle
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	localparam logic [1:0] PH_LOW = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_SETTLE = 2'd2;

	state_t          state_q;
	logic [PC_W-1:0] pc_q;
	logic [1:0]      phase_q;
	logic [7:0]      byte_q;
	logic            rs_q;
	logic [3:0]      data_q;

	elem_t       elem;
	logic [3:0]  nib_val;
	logic [15:0] wait_hold;
	logic [7:0]  cursor_byte;

	assign cursor_byte = {1'b1, 7'({1'b0, start_col} +
		((start_row != 2'd0) ? ROW1_OFFSET : 7'h00))};

	always_comb begin
		elem = seq_rom(pc_q);
		case (elem.nsrc)
			NSRC_HI: nib_val = byte_q[7:4];
			NSRC_LO: nib_val = byte_q[3:0];
			default: nib_val = elem.nconst;
		endcase
		case (elem.wsel)
			WSEL_POWER: wait_hold = cfg.power_wait;
			WSEL_LONG:  wait_hold = WAIT_LONG_US;
			WSEL_SHORT: wait_hold = WAIT_SHORT_US;
			default:    wait_hold = cfg.clear_wait;
		endcase
		push = (state_q == S_RUN) && space;
		pin.rs = rs_q;
		if (elem.kind == ELEM_NIB) begin
			pin.en = (phase_q == PH_HIGH);
			pin.nibble = nib_val;
			pin.hold = (phase_q == PH_SETTLE) ? 16'(cfg.settle) : 16'(cfg.pulse);
			pin.last = elem.last && (phase_q == PH_SETTLE);
		end else begin
			pin.en = 1'b0;
			pin.nibble = data_q;
			pin.hold = wait_hold;
			pin.last = elem.last;
		end
	end

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= PC_INIT;
			phase_q <= PH_LOW;
			byte_q <= 8'h00;
			rs_q <= 1'b0;
			data_q <= 4'h0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						phase_q <= PH_LOW;
						case (start_op)
							OP_CMD: begin
								rs_q <= 1'b0;
								byte_q <= start_byte;
								pc_q <= PC_BYTE;
								state_q <= S_RUN;
							end
							OP_DATA: begin
								rs_q <= 1'b1;
								byte_q <= start_byte;
								pc_q <= PC_BYTE;
								state_q <= S_RUN;
							end
							OP_CURSOR: begin
								rs_q <= 1'b0;
								byte_q <= cursor_byte;
								pc_q <= PC_BYTE;
								state_q <= S_RUN;
							end
							OP_CLEAR: begin
								rs_q <= 1'b0;
								pc_q <= PC_CLEAR;
								state_q <= S_RUN;
							end
							OP_INIT: begin
								rs_q <= 1'b0;
								pc_q <= PC_INIT;
								state_q <= S_RUN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RUN: begin
					if (push) begin
						if (elem.kind == ELEM_NIB) begin
							if (phase_q == PH_LOW) begin
								data_q <= nib_val;
							end
							if (phase_q == PH_SETTLE) begin
								phase_q <= PH_LOW;
								if (elem.last) begin
									state_q <= S_IDLE;
								end else begin
									pc_q <= pc_q + PC_W'(1);
								end
							end else begin
								phase_q <= phase_q + 2'd1;
							end
						end else begin
							if (elem.last) begin
								state_q <= S_IDLE;
							end else begin
								pc_q <= pc_q + PC_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/lcd4_out.sv
// output register for pin states, parts the sequencer from the consumer
// depends on lcd4_pkg
`timescale 1ns / 1ps

module lcd4_out
	import lcd4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pin_state_t pin,
	output logic       space,
	output logic       out_valid,
	input  logic       out_ready,
	output pin_state_t held
);

	logic       valid_q;
	pin_state_t data_q;

	// slot frees up in the same cycle it is taken
	assign space = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign held = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && space) begin
			data_q <= pin;
		end
	end

endmodule
